// File: design/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types, register map and CRC-8 helper for the angle frame checker.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int ANGLE_W   = 21;
    localparam int WARN_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    localparam logic [APB_ADDR_W-1:0] REG_CRC_ENABLE = 2'd0;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [WARN_W-1:0]  warning;
        logic               status;
    } afc_result_t;

    // one byte through CRC-8, MSB first, no reflection
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[BYTE_W-1])
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[BYTE_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/afc_frame.sv
// ----------------------------------------------------------------------------
// afc_frame
// Frame tracker: collects angle bytes, runs the CRC and builds the result.
// ----------------------------------------------------------------------------
module afc_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic [7:0]           data_byte,
    input  logic                 first,
    input  logic                 crc_enable,
    output logic                 result_valid,
    output afc_pkg::afc_result_t result
);
    import afc_pkg::*;

    typedef enum logic [2:0] {
        POS_MID  = 3'd1,
        POS_LOW  = 3'd2,
        POS_CRC  = 3'd3,
        POS_IDLE = 3'd4
    } pos_t;

    pos_t               pos_reg, pos_next;
    logic [BYTE_W-1:0]  crc_reg, crc_next;
    logic [15:0]        high_reg, high_next;
    logic [BYTE_W-1:0]  low_reg, low_next;

    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        result_valid = 1'b0;
        result.angle   = {high_reg, low_reg[7:3]};
        result.warning = low_reg[2:0];
        result.status  = 1'b0;
        if (byte_valid)
        begin
            if (first)
            begin
                high_next = {data_byte, 8'h00};
                crc_next  = crc8_update(CRC_INIT, data_byte);
                pos_next  = POS_MID;
            end
            else
            begin
                case (pos_reg)
                    POS_MID:
                    begin
                        high_next = {high_reg[15:8], data_byte};
                        crc_next  = crc8_update(crc_reg, data_byte);
                        pos_next  = POS_LOW;
                    end
                    POS_LOW:
                    begin
                        low_next = data_byte;
                        crc_next = crc8_update(crc_reg, data_byte);
                        if (crc_enable)
                            pos_next = POS_CRC;
                        else
                        begin
                            pos_next       = POS_IDLE;
                            result_valid   = 1'b1;
                            result.angle   = {high_reg, data_byte[7:3]};
                            result.warning = data_byte[2:0];
                        end
                    end
                    POS_CRC:
                    begin
                        pos_next      = POS_IDLE;
                        result_valid  = 1'b1;
                        result.status = (crc_reg != data_byte);
                    end
                    default:
                        pos_next = POS_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_IDLE;
            crc_reg  <= CRC_INIT;
            high_reg <= '0;
            low_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

endmodule

// File: design/afc_out_buf.sv
// ----------------------------------------------------------------------------
// afc_out_buf
// Result register with a skid entry so upstream ready is a flop output.
// ----------------------------------------------------------------------------
module afc_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  afc_pkg::afc_result_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output afc_pkg::afc_result_t out_data,
    input  logic                 out_ready
);
    import afc_pkg::*;

    logic        main_valid_reg;
    afc_result_t main_reg;
    logic        skid_valid_reg;
    afc_result_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || out_ready)
            begin
                // main slot frees up: refill from skid first, else from input
                if (skid_valid_reg)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    main_valid_reg <= in_valid;
            end
            else if (in_valid && !skid_valid_reg)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (in_valid)
                main_reg <= in_data;
        end
        else if (in_valid && !skid_valid_reg)
            skid_reg <= in_data;
    end

endmodule

// File: design/encoder_angle_frame_checker.sv
// ----------------------------------------------------------------------------
// encoder_angle_frame_checker
// Angle sensor frame checker with CRC-8 (poly 0x07, init 0).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one received byte per word, tdata = data byte, tuser = first
//   (high angle byte that starts a frame). Frames are high, middle and low
//   byte, plus a CRC byte when crc_enable is set over APB (byte addr 0).
//   m_axis: one word per completed frame, tdata = {warning, angle},
//   tuser = status (1 = CRC mismatch, angle/warning not to be used).
//   Bytes outside a frame produce nothing; a first byte mid-frame drops the
//   partial frame.
// Timing:
//   One byte accepted per cycle while s_axis_tready is high. The result of
//   a frame's final byte is registered into main, or skid if main stalls. The
//   CRC is a byte-wide update in the same cycle the byte arrives.
// Reset:
//   Frame tracker idle (waiting for first), crc_enable = 0, output empty.
// Backpressure:
//   A two-entry output register (main + skid) absorbs one stalled word;
//   s_axis_tready drops while the skid entry holds a word and comes back
//   the cycle after the main word is taken.
// ----------------------------------------------------------------------------
module encoder_angle_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] angle, [23:21] warning
    output logic        m_axis_tuser    // [0] status
);
    import afc_pkg::*;

    logic        crc_enable_reg;
    logic        byte_valid;
    logic        result_valid;
    afc_result_t result;
    afc_result_t out_word;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_enable_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr == REG_CRC_ENABLE)
            crc_enable_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_CRC_ENABLE)
            prdata = {{(APB_DATA_W-1){1'b0}}, crc_enable_reg};
    end

    assign byte_valid = s_axis_tvalid && s_axis_tready;

    afc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .data_byte    (s_axis_tdata),
        .first        (s_axis_tuser),
        .crc_enable   (crc_enable_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    afc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (result_valid),
        .in_data   (result),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_word),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_word.warning, out_word.angle};
    assign m_axis_tuser = out_word.status;

endmodule
